// ===== hdl/open_address_hash_insert_top_assert.svh =====
// assertion macros shared by the checker
`ifndef OPEN_ADDRESS_HASH_INSERT_TOP_ASSERT_SVH
`define OPEN_ADDRESS_HASH_INSERT_TOP_ASSERT_SVH

// same-cycle implication
`define OHI_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OHI_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ohi_pkg.sv =====
package ohi_pkg;

   localparam int CAPACITY  = 64;
   localparam int SLOT_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int KEY_W     = 31;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int MIN_SIZE  = 7;

   // remainder unit: bits retired per cycle
   localparam int DIV_BITS   = 4;
   localparam int DIV_ROUNDS = (KEY_W + DIV_BITS - 1) / DIV_BITS;
   localparam int DIV_W      = DIV_ROUNDS * DIV_BITS;
   localparam int ROUND_W    = (DIV_ROUNDS > 1) ? $clog2(DIV_ROUNDS) : 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_PRESENT = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_EXHAUST = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_SIZE = 1'b0,
      CSR_PROBE_MODE = 1'b1
   } csr_type;

   // table size clamped to the supported range
   function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] s);
      logic [CNT_W-1:0] r;
      if (CNT_W'(s) < CNT_W'(MIN_SIZE)) begin
         r = CNT_W'(MIN_SIZE);
      end else if (32'(s) > 32'(CAPACITY)) begin
         r = CNT_W'(CAPACITY);
      end else begin
         r = CNT_W'(s);
      end
      return r;
   endfunction

endpackage

// ===== hdl/ohi_ram.sv =====
module ohi_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 31
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/ohi_mod.sv =====
module ohi_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ohi_pkg::KEY_W-1:0]   dividend,
   input  logic [ohi_pkg::CNT_W-1:0]   divisor,
   output logic                        done,
   output logic [ohi_pkg::SLOT_W-1:0]  remainder
);
   import ohi_pkg::*;

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [DIV_W-1:0]   shift_ff, shift_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   div_ff, div_in;
   logic [DIV_W-1:0]   shift_step;
   logic [CNT_W-1:0]   rem_step;

   // restoring remainder, DIV_BITS dividend bits per cycle, msb first
   always_comb begin : div_step
      logic [CNT_W-1:0] r;
      logic [CNT_W-1:0] t;
      logic [DIV_W-1:0] s;
      r = rem_ff;
      s = shift_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         t = {r[CNT_W-2:0], s[DIV_W-1]};
         s = {s[DIV_W-2:0], 1'b0};
         if (t >= div_ff) begin
            t = t - div_ff;
         end
         r = t;
      end
      rem_step   = r;
      shift_step = s;
   end

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      round_in = round_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         run_in   = 1'b1;
         round_in = '0;
         shift_in = DIV_W'(dividend);
         rem_in   = '0;
         div_in   = divisor;
      end else if (run_ff) begin
         shift_in = shift_step;
         rem_in   = rem_step;
         round_in = round_ff + ROUND_W'(1);
         if (round_ff == ROUND_W'(DIV_ROUNDS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[SLOT_W-1:0];

endmodule

// ===== hdl/open_address_hash_insert_top.sv =====
// Open-addressing hash table of 31-bit keys, up to 64 slots.
// Command channel: drive req_opcode, req_key and req_slot_index with start high;
// the word is taken at a rising edge where busy is low. One result word per
// command appears on the rsp_ ports for exactly one cycle with rsp_strobe high;
// the receiver cannot hold it off, so it must sample on the strobe.
// Steps from the accepting edge to the strobe cycle:
//   clear, unused opcode, insert into a full table: result registered at the accepting edge
//   read slot: one synchronous key RAM read, then the result word
//   insert: the key mod size unit (8 rounds at 4 bits plus a hand-off) gives
//   the home slot; then each probe checks that slot's valid bit. An empty slot
//   takes the key; an occupied probe costs a key RAM read and a compare, and
//   the search ends on a match (present) or once size occupied probes have
//   run out (exhaust).
// One command is in flight at a time; busy is high until its result is out,
// and a new command may be taken in the strobe cycle.
// Config: csr_write_en, csr_index, csr_wdata; write only while busy is low.
// Reset (synchronous, active high) empties the table and sets table size 7,
// linear probing. Key RAM content is not cleared; slot valid bits are.
module open_address_hash_insert_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_opcode,
   input  logic [ohi_pkg::KEY_W-1:0]        req_key,
   input  logic [ohi_pkg::SLOT_W-1:0]       req_slot_index,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic [ohi_pkg::SLOT_W-1:0]       rsp_position,
   output logic                             rsp_slot_valid,
   output logic [ohi_pkg::KEY_W-1:0]        rsp_slot_key,
   output logic                             rsp_table_full,
   input  logic                             csr_write_en,
   input  logic [ohi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ohi_pkg::CFG_W-1:0]        csr_wdata
);
   import ohi_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_DIV   = 5'b00010,
      S_PROBE = 5'b00100,
      S_CMP   = 5'b01000,
      S_READ  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   cfg_size_ff;
   logic               cfg_mode_ff;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]   size_ff, size_in;
   logic               mode_ff, mode_in;
   logic [SLOT_W-1:0]  cur_ff, cur_in;
   logic [CNT_W-1:0]   inc_ff, inc_in;
   logic [CNT_W-1:0]   probes_ff, probes_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CAPACITY-1:0] used_ff, used_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_position_ff, rsp_position_in;
   logic               rsp_slot_valid_ff, rsp_slot_valid_in;
   logic [KEY_W-1:0]   rsp_slot_key_ff, rsp_slot_key_in;
   logic               rsp_table_full_ff, rsp_table_full_in;

   logic               accept;
   logic [CNT_W-1:0]   cfg_eff;
   logic               ram_we;
   logic [SLOT_W-1:0]  ram_addr;
   logic [KEY_W-1:0]   ram_rdata;
   logic               div_start;
   logic               div_done;
   logic [SLOT_W-1:0]  div_rem;
   logic [CNT_W-1:0]   step;
   logic [CNT_W-1:0]   sum;
   logic [CNT_W-1:0]   cur_next;
   logic [CNT_W-1:0]   inc_sum;
   logic [CNT_W-1:0]   inc_next;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign cfg_eff = eff_size(cfg_size_ff);

   ohi_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_W)
   ) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (key_ff),
      .rdata (ram_rdata)
   );

   ohi_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_key),
      .divisor   (cfg_eff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // next probe slot; the quadratic step is kept reduced mod size
   assign step     = mode_ff ? inc_ff : CNT_W'(1);
   assign sum      = CNT_W'(cur_ff) + step;
   assign cur_next = (sum >= size_ff) ? (sum - size_ff) : sum;
   assign inc_sum  = inc_ff + CNT_W'(2);
   assign inc_next = (inc_sum >= size_ff) ? (inc_sum - size_ff) : inc_sum;

   always_comb begin
      state_in          = state_ff;
      key_in            = key_ff;
      size_in           = size_ff;
      mode_in           = mode_ff;
      cur_in            = cur_ff;
      inc_in            = inc_ff;
      probes_in         = probes_ff;
      idx_in            = idx_ff;
      count_in          = count_ff;
      used_in           = used_ff;
      ram_we            = 1'b0;
      ram_addr          = cur_ff;
      div_start         = 1'b0;
      rsp_strobe_in     = 1'b0;
      rsp_status_in     = STAT_DONE;
      rsp_position_in   = '0;
      rsp_slot_valid_in = 1'b0;
      rsp_slot_key_in   = '0;
      rsp_table_full_in = (count_ff >= size_ff);

      unique case (state_ff)
         S_IDLE: begin
            ram_addr = req_slot_index;
            if (accept) begin
               size_in = cfg_eff;
               mode_in = cfg_mode_ff;
               case (req_opcode)
                  OP_INSERT: begin
                     if (count_ff >= cfg_eff) begin
                        rsp_strobe_in     = 1'b1;
                        rsp_status_in     = STAT_FULL;
                        rsp_table_full_in = 1'b1;
                     end else begin
                        key_in    = req_key;
                        div_start = 1'b1;
                        state_in  = S_DIV;
                     end
                  end
                  OP_READ: begin
                     idx_in   = req_slot_index;
                     state_in = S_READ;
                  end
                  OP_CLEAR: begin
                     used_in           = '0;
                     count_in          = '0;
                     rsp_strobe_in     = 1'b1;
                     // size is never below seven, so an empty table is not full
                     rsp_table_full_in = 1'b0;
                  end
                  default: begin
                     rsp_strobe_in     = 1'b1;
                     rsp_table_full_in = (count_ff >= cfg_eff);
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               cur_in    = div_rem;
               inc_in    = CNT_W'(1);
               probes_in = '0;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            if (!used_ff[cur_ff]) begin
               ram_we            = 1'b1;
               used_in[cur_ff]   = 1'b1;
               count_in          = count_ff + CNT_W'(1);
               rsp_strobe_in     = 1'b1;
               rsp_status_in     = STAT_DONE;
               rsp_position_in   = cur_ff;
               rsp_table_full_in = ((count_ff + CNT_W'(1)) >= size_ff);
               state_in          = S_IDLE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (ram_rdata == key_ff) begin
               rsp_strobe_in   = 1'b1;
               rsp_status_in   = STAT_PRESENT;
               rsp_position_in = cur_ff;
               state_in        = S_IDLE;
            end else if ((probes_ff + CNT_W'(1)) == size_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STAT_EXHAUST;
               state_in      = S_IDLE;
            end else begin
               cur_in    = cur_next[SLOT_W-1:0];
               inc_in    = inc_next;
               probes_in = probes_ff + CNT_W'(1);
               state_in  = S_PROBE;
            end
         end
         S_READ: begin
            rsp_strobe_in     = 1'b1;
            rsp_position_in   = idx_ff;
            rsp_slot_valid_in = used_ff[idx_ff];
            rsp_slot_key_in   = used_ff[idx_ff] ? ram_rdata : '0;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         cfg_size_ff   <= CFG_W'(MIN_SIZE);
         cfg_mode_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_TABLE_SIZE: cfg_size_ff <= csr_wdata;
               CSR_PROBE_MODE: cfg_mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff            <= key_in;
      size_ff           <= size_in;
      mode_ff           <= mode_in;
      cur_ff            <= cur_in;
      inc_ff            <= inc_in;
      probes_ff         <= probes_in;
      idx_ff            <= idx_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_position_ff   <= rsp_position_in;
      rsp_slot_valid_ff <= rsp_slot_valid_in;
      rsp_slot_key_ff   <= rsp_slot_key_in;
      rsp_table_full_ff <= rsp_table_full_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_slot_valid = rsp_slot_valid_ff;
   assign rsp_slot_key   = rsp_slot_key_ff;
   assign rsp_table_full = rsp_table_full_ff;

endmodule

// ===== hdl/ohi_checker.sv =====
`include "open_address_hash_insert_top_assert.svh"

module ohi_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_strobe,
   input logic [1:0]                  rsp_status,
   input logic [ohi_pkg::SLOT_W-1:0]  rsp_position,
   input logic                        rsp_slot_valid,
   input logic [ohi_pkg::KEY_W-1:0]   rsp_slot_key,
   input logic                        rsp_table_full
);
   import ohi_pkg::*;

   // a result word only shows once the command has finished
   `OHI_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy, "result word while busy")

   // an accepted command either finishes at once or holds busy
   `OHI_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_strobe, "command lost")

   // rejected inserts name no slot
   `OHI_ASSERT_NOW(a_reject_pos,
      rsp_strobe && (rsp_status == STAT_FULL || rsp_status == STAT_EXHAUST),
      rsp_position == '0 && !rsp_slot_valid, "rejected insert with a slot")

   // full rejection implies the full flag, empty slot reads zero key
   `OHI_ASSERT_NOW(a_full_flag, rsp_strobe && rsp_status == STAT_FULL,
      rsp_table_full && (rsp_slot_valid || rsp_slot_key == '0), "full status inconsistent")

endmodule

bind open_address_hash_insert_top ohi_checker u_ohi_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_strobe     (rsp_strobe),
   .rsp_status     (rsp_status),
   .rsp_position   (rsp_position),
   .rsp_slot_valid (rsp_slot_valid),
   .rsp_slot_key   (rsp_slot_key),
   .rsp_table_full (rsp_table_full)
);
